### rtl/assert_macros.svh
// Assertion macros used by the decoder top module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Implication checked at every rising clock edge outside reset.
`define SGOD_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("sgod assertion failed");
// Implication checked at every rising clock edge, reset included.
`define SGOD_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("sgod assertion failed");
`else
`define SGOD_ASSERT(label, clk, rst, prop)
`define SGOD_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

### rtl/sgod_pkg.sv
package sgod_pkg;
   // Largest point count supported by the output index field.
   localparam int MAX_POINTS_DEF = 64;
   localparam int PTR_W = 6;

   // Result status codes.
   localparam logic [1:0] ST_POINT     = 2'd0;
   localparam logic [1:0] ST_EMPTY     = 2'd1;
   localparam logic [1:0] ST_COMPOSITE = 2'd2;
   localparam logic [1:0] ST_LIMIT     = 2'd3;

   // Flag bits of a point.
   localparam int FL_ON     = 0;
   localparam int FL_XSHORT = 1;
   localparam int FL_YSHORT = 2;
   localparam int FL_REPEAT = 3;
   localparam int FL_XSAME  = 4;
   localparam int FL_YSAME  = 5;
   localparam logic [7:0] FLAG_KEEP = 8'h37;
   localparam logic [15:0] HEAD_SKIP = 16'd8;

   // Access to the point store: one address, shared by read and write.
   typedef struct packed {
      logic             flag_we;
      logic             x_we;
      logic             rd_en;
      logic [PTR_W-1:0] addr;
      logic [5:0]       flag_wdata;
      logic [15:0]      x_wdata;
   } mem_req_type;

   // One result item.
   typedef struct packed {
      logic [5:0]  point_index;
      logic [15:0] x_coord;
      logic [15:0] y_coord;
      logic        on_curve;
      logic        contour_end;
      logic [1:0]  status;
      logic        last;
   } result_type;
endpackage

### rtl/simple_glyph_outline_decoder.sv
// Simple glyph outline decoder: takes the bytes of one simple glyph record, one
// request each, and returns one response per outline point (or one status
// response for an empty, composite or oversized glyph). After a repeat count
// byte the input stalls while the repeated flag is copied, entry by entry, into
// the single-port point store. In the x and y passes each point takes a store
// read, then an evaluation step that also takes a short delta byte or the high
// byte of a word delta; the low byte of a word delta is taken in a further step,
// and points with no delta byte need only the read and the evaluation. A
// response waits in an output register while the next request is taken.
`include "assert_macros.svh"
module simple_glyph_outline_decoder #(
   parameter int MAX_POINTS = sgod_pkg::MAX_POINTS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_glyph_start,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [5:0]  rsp_point_index,
   output logic signed [15:0] rsp_x_coord,
   output logic signed [15:0] rsp_y_coord,
   output logic        rsp_on_curve,
   output logic        rsp_contour_end,
   output logic [1:0]  rsp_status,
   output logic        rsp_last
);
   import sgod_pkg::*;

   mem_req_type mem_req;
   result_type  result;
   result_type  rsp_ff;
   logic        rsp_valid_ff;
   logic        emit;
   logic        slot_free;
   logic [5:0]  flag_rd;
   logic [15:0] x_rd;
   logic        status_rsp;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   sgod_parser #(.MAX_POINTS(MAX_POINTS)) u_parser (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_data   (req_data_byte),
      .in_start  (req_glyph_start),
      .in_ready  (req_ready),
      .slot_free (slot_free),
      .emit      (emit),
      .result    (result),
      .mem_req   (mem_req),
      .flag_rd   (flag_rd),
      .x_rd      (x_rd)
   );

   sgod_point_store #(.MAX_POINTS(MAX_POINTS)) u_store (
      .clock   (clock),
      .mem_req (mem_req),
      .flag_rd (flag_rd),
      .x_rd    (x_rd)
   );

   // Output register for the response channel.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_point_index = rsp_ff.point_index;
   assign rsp_x_coord     = rsp_ff.x_coord;
   assign rsp_y_coord     = rsp_ff.y_coord;
   assign rsp_on_curve    = rsp_ff.on_curve;
   assign rsp_contour_end = rsp_ff.contour_end;
   assign rsp_status      = rsp_ff.status;
   assign rsp_last        = rsp_ff.last;

   // A status response is on the channel.
   assign status_rsp = rsp_valid && (rsp_status != ST_POINT);

   `SGOD_ASSERT(a_emit_slot, clock, reset, emit |-> slot_free)
   `SGOD_ASSERT(a_status_last, clock, reset, status_rsp |-> rsp_last)
   `SGOD_ASSERT(a_status_x, clock, reset, status_rsp |-> (rsp_x_coord == 16'sd0))
   `SGOD_ASSERT(a_status_index, clock, reset, status_rsp |-> (rsp_point_index == 6'd0))
endmodule

### rtl/sgod_point_store.sv
module sgod_point_store #(
   parameter int MAX_POINTS = 64
) (
   input  logic                clock,
   input  sgod_pkg::mem_req_type mem_req,
   output logic [5:0]          flag_rd,
   output logic [15:0]         x_rd
);
   import sgod_pkg::*;

   localparam int IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

   logic [5:0]  flag_mem [MAX_POINTS];
   logic [15:0] x_mem    [MAX_POINTS];
   logic [IW-1:0] addr;

   assign addr = mem_req.addr[IW-1:0];

   // Single-port arrays with registered read data.
   always_ff @(posedge clock) begin
      if (mem_req.flag_we) begin
         flag_mem[addr] <= mem_req.flag_wdata;
      end
      if (mem_req.x_we) begin
         x_mem[addr] <= mem_req.x_wdata;
      end
      if (mem_req.rd_en) begin
         flag_rd <= flag_mem[addr];
         x_rd    <= x_mem[addr];
      end
   end
endmodule

### rtl/sgod_parser.sv
module sgod_parser #(
   parameter int MAX_POINTS = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  logic [7:0]            in_data,
   input  logic                  in_start,
   output logic                  in_ready,
   input  logic                  slot_free,
   output logic                  emit,
   output sgod_pkg::result_type  result,
   output sgod_pkg::mem_req_type mem_req,
   input  logic [5:0]            flag_rd,
   input  logic [15:0]           x_rd
);
   import sgod_pkg::*;

   localparam int IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int CW = $clog2(MAX_POINTS + 1);

   localparam logic [4:0] S_IDLE     = 5'd0;
   localparam logic [4:0] S_CNT_LO   = 5'd1;
   localparam logic [4:0] S_HEAD     = 5'd2;
   localparam logic [4:0] S_END_HI   = 5'd3;
   localparam logic [4:0] S_END_LO   = 5'd4;
   localparam logic [4:0] S_INS_HI   = 5'd5;
   localparam logic [4:0] S_INS_LO   = 5'd6;
   localparam logic [4:0] S_INS_SKIP = 5'd7;
   localparam logic [4:0] S_FLAG     = 5'd8;
   localparam logic [4:0] S_REPEAT   = 5'd9;
   localparam logic [4:0] S_FILL     = 5'd10;
   localparam logic [4:0] S_X_FETCH  = 5'd11;
   localparam logic [4:0] S_X_EVAL   = 5'd12;
   localparam logic [4:0] S_X_LO     = 5'd13;
   localparam logic [4:0] S_Y_FETCH  = 5'd14;
   localparam logic [4:0] S_Y_EVAL   = 5'd15;
   localparam logic [4:0] S_Y_LO     = 5'd16;

   logic [4:0]            state_ff, state_in;
   logic [15:0]           count_ff, count_in;
   logic [15:0]           contours_ff, contours_in;
   logic [CW-1:0]         total_ff, total_in;
   logic [CW-1:0]         walk_ff, walk_in;
   logic [7:0]            hold_ff, hold_in;
   logic [15:0]           coord_ff, coord_in;
   logic [5:0]            rep_flag_ff, rep_flag_in;
   logic [7:0]            rep_cnt_ff, rep_cnt_in;
   logic [MAX_POINTS-1:0] marks_ff, marks_in;

   logic          acc;
   logic [CW-1:0] walk_next;
   logic          walk_done;
   logic [15:0]   word;
   logic [15:0]   short_x, short_y;
   logic          x_needs, y_needs;
   logic [IW-1:0] idx;

   assign walk_next = walk_ff + CW'(1);
   assign walk_done = (walk_next >= total_ff);
   assign word      = {hold_ff, in_data};
   assign idx       = walk_ff[IW-1:0];
   assign short_x   = flag_rd[FL_XSAME] ? coord_ff + {8'd0, in_data}
                                        : coord_ff - {8'd0, in_data};
   assign short_y   = flag_rd[FL_YSAME] ? coord_ff + {8'd0, in_data}
                                        : coord_ff - {8'd0, in_data};
   assign x_needs   = flag_rd[FL_XSHORT] || !flag_rd[FL_XSAME];
   assign y_needs   = flag_rd[FL_YSHORT] || !flag_rd[FL_YSAME];

   // Which states take a byte; states that may emit also need the output slot.
   always_comb begin
      unique case (state_ff)
         S_IDLE, S_HEAD, S_END_HI, S_INS_HI, S_INS_LO, S_INS_SKIP,
         S_FLAG, S_REPEAT, S_X_LO: in_ready = 1'b1;
         S_CNT_LO, S_END_LO, S_Y_LO: in_ready = slot_free;
         S_X_EVAL: in_ready = x_needs;
         S_Y_EVAL: in_ready = y_needs && slot_free;
         default: in_ready = 1'b0;
      endcase
   end

   assign acc = in_valid && in_ready;

   // Next-state logic of the parser and point walks.
   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      contours_in = contours_ff;
      total_in    = total_ff;
      walk_in     = walk_ff;
      hold_in     = hold_ff;
      coord_in    = coord_ff;
      rep_flag_in = rep_flag_ff;
      rep_cnt_in  = rep_cnt_ff;
      marks_in    = marks_ff;
      emit        = 1'b0;
      result      = '0;
      mem_req     = '0;
      mem_req.addr = PTR_W'(walk_ff);

      if (acc && in_start) begin
         state_in    = S_CNT_LO;
         count_in    = '0;
         contours_in = '0;
         total_in    = '0;
         walk_in     = '0;
         hold_in     = in_data;
         coord_in    = '0;
         rep_flag_in = '0;
         rep_cnt_in  = '0;
         marks_in    = '0;
      end else begin
         unique case (state_ff)
            S_CNT_LO: if (acc) begin
               if (hold_ff[7]) begin
                  emit = 1'b1;
                  result.status = ST_COMPOSITE;
                  result.last = 1'b1;
                  state_in = S_IDLE;
               end else if (word == 16'd0) begin
                  emit = 1'b1;
                  result.status = ST_EMPTY;
                  result.last = 1'b1;
                  state_in = S_IDLE;
               end else begin
                  contours_in = word;
                  count_in = HEAD_SKIP;
                  state_in = S_HEAD;
               end
            end
            S_HEAD: if (acc) begin
               count_in = count_ff - 16'd1;
               if (count_ff == 16'd1) state_in = S_END_HI;
            end
            S_END_HI: if (acc) begin
               hold_in = in_data;
               state_in = S_END_LO;
            end
            S_END_LO: if (acc) begin
               if (word < 16'(MAX_POINTS)) marks_in[word[IW-1:0]] = 1'b1;
               contours_in = contours_ff - 16'd1;
               if (contours_ff != 16'd1) begin
                  state_in = S_END_HI;
               end else if (word >= 16'(MAX_POINTS)) begin
                  emit = 1'b1;
                  result.status = ST_LIMIT;
                  result.last = 1'b1;
                  state_in = S_IDLE;
               end else begin
                  total_in = CW'(word) + CW'(1);
                  state_in = S_INS_HI;
               end
            end
            S_INS_HI: if (acc) begin
               hold_in = in_data;
               state_in = S_INS_LO;
            end
            S_INS_LO: if (acc) begin
               count_in = word;
               walk_in = '0;
               state_in = (word == 16'd0) ? S_FLAG : S_INS_SKIP;
            end
            S_INS_SKIP: if (acc) begin
               count_in = count_ff - 16'd1;
               if (count_ff == 16'd1) state_in = S_FLAG;
            end
            S_FLAG: if (acc) begin
               mem_req.flag_we = 1'b1;
               mem_req.flag_wdata = 6'(in_data & FLAG_KEEP);
               walk_in = walk_next;
               if (in_data[FL_REPEAT]) begin
                  rep_flag_in = 6'(in_data & FLAG_KEEP);
                  state_in = S_REPEAT;
               end else if (walk_done) begin
                  walk_in = '0;
                  coord_in = '0;
                  state_in = S_X_FETCH;
               end
            end
            S_REPEAT: if (acc) begin
               rep_cnt_in = in_data;
               state_in = S_FILL;
            end
            // Copy the repeated flag one entry a cycle.
            S_FILL: begin
               if (rep_cnt_ff != 8'd0 && walk_ff < total_ff) begin
                  mem_req.flag_we = 1'b1;
                  mem_req.flag_wdata = rep_flag_ff;
                  walk_in = walk_next;
                  rep_cnt_in = rep_cnt_ff - 8'd1;
               end else if (walk_ff >= total_ff) begin
                  walk_in = '0;
                  coord_in = '0;
                  state_in = S_X_FETCH;
               end else begin
                  state_in = S_FLAG;
               end
            end
            S_X_FETCH: begin
               mem_req.rd_en = 1'b1;
               state_in = S_X_EVAL;
            end
            S_X_EVAL: begin
               if (!x_needs || (acc && flag_rd[FL_XSHORT])) begin
                  mem_req.x_we = 1'b1;
                  mem_req.x_wdata = x_needs ? short_x : coord_ff;
                  coord_in = mem_req.x_wdata;
                  walk_in = walk_next;
                  state_in = S_X_FETCH;
                  if (walk_done) begin
                     walk_in = '0;
                     coord_in = '0;
                     state_in = S_Y_FETCH;
                  end
               end else if (acc) begin
                  hold_in = in_data;
                  state_in = S_X_LO;
               end
            end
            S_X_LO: if (acc) begin
               mem_req.x_we = 1'b1;
               mem_req.x_wdata = coord_ff + word;
               coord_in = mem_req.x_wdata;
               walk_in = walk_next;
               state_in = S_X_FETCH;
               if (walk_done) begin
                  walk_in = '0;
                  coord_in = '0;
                  state_in = S_Y_FETCH;
               end
            end
            S_Y_FETCH: begin
               mem_req.rd_en = 1'b1;
               state_in = S_Y_EVAL;
            end
            S_Y_EVAL: begin
               if ((!y_needs && slot_free) || (acc && flag_rd[FL_YSHORT])) begin
                  coord_in = y_needs ? short_y : coord_ff;
                  emit = 1'b1;
                  walk_in = walk_next;
                  state_in = walk_done ? S_IDLE : S_Y_FETCH;
               end else if (acc) begin
                  hold_in = in_data;
                  state_in = S_Y_LO;
               end
            end
            S_Y_LO: if (acc) begin
               coord_in = coord_ff + word;
               emit = 1'b1;
               walk_in = walk_next;
               state_in = walk_done ? S_IDLE : S_Y_FETCH;
            end
            default: ;
         endcase
         // Point results carry the stored x and the fresh y.
         if (state_ff == S_Y_EVAL || state_ff == S_Y_LO) begin
            result.point_index = 6'(walk_ff);
            result.x_coord = x_rd;
            result.y_coord = coord_in;
            result.on_curve = flag_rd[FL_ON];
            result.contour_end = marks_ff[idx];
            result.status = ST_POINT;
            result.last = (walk_next == total_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         count_ff    <= '0;
         contours_ff <= '0;
         total_ff    <= '0;
         walk_ff     <= '0;
         hold_ff     <= '0;
         coord_ff    <= '0;
         rep_flag_ff <= '0;
         rep_cnt_ff  <= '0;
         marks_ff    <= '0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         contours_ff <= contours_in;
         total_ff    <= total_in;
         walk_ff     <= walk_in;
         hold_ff     <= hold_in;
         coord_ff    <= coord_in;
         rep_flag_ff <= rep_flag_in;
         rep_cnt_ff  <= rep_cnt_in;
         marks_ff    <= marks_in;
      end
   end
endmodule
